FILE: rtl/core/ed3d_pkg.sv
// shared constants for the 3d euclidean distance block
`default_nettype none

package ed3d_pkg;

   // default coordinate width, signed q8.8
   localparam int COORD_WIDTH_DEF = 16;

   // width of the distance result
   localparam int DIST_WIDTH = 17;

   // number of axes per point
   localparam int NUM_AXES = 3;

endpackage : ed3d_pkg

`default_nettype wire

FILE: rtl/core/ed3d_front.sv
// front end: per-axis difference magnitude, squares and their sum
`default_nettype none

module ed3d_front #(
   parameter int COORD_WIDTH = ed3d_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [COORD_WIDTH-1:0]     in_a [ed3d_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0]     in_b [ed3d_pkg::NUM_AXES],
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic        [2*COORD_WIDTH+1:0]   out_sum
);

   import ed3d_pkg::*;

   localparam int SqWidth  = 2 * COORD_WIDTH;
   localparam int SumWidth = SqWidth + 2;

   logic                         mag_valid_ff, mag_valid_in;
   logic                         sq_valid_ff, sq_valid_in;
   logic                         sum_valid_ff, sum_valid_in;
   logic                         mag_ready, sq_ready, sum_ready;
   logic signed [COORD_WIDTH:0]  diff [NUM_AXES];
   logic [COORD_WIDTH-1:0]       mag_in [NUM_AXES];
   logic [COORD_WIDTH-1:0]       mag_ff [NUM_AXES];
   logic [SqWidth-1:0]           sq_in [NUM_AXES];
   logic [SqWidth-1:0]           sq_ff [NUM_AXES];
   logic [SumWidth-1:0]          sum_in;
   logic [SumWidth-1:0]          sum_ff;

   // stage ready chain, a stage moves when it is empty or its successor takes
   always_comb begin
      sum_ready = !sum_valid_ff || out_ready;
      sq_ready  = !sq_valid_ff || sum_ready;
      mag_ready = !mag_valid_ff || sq_ready;
      in_ready  = mag_ready;
      mag_valid_in = mag_ready ? in_valid : mag_valid_ff;
      sq_valid_in  = sq_ready ? mag_valid_ff : sq_valid_ff;
      sum_valid_in = sum_ready ? sq_valid_ff : sum_valid_ff;
   end

   // difference magnitude per axis, sign extended by one bit
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         diff[i] = $signed({in_b[i][COORD_WIDTH-1], in_b[i]})
                 - $signed({in_a[i][COORD_WIDTH-1], in_a[i]});
         mag_in[i] = diff[i][COORD_WIDTH] ? COORD_WIDTH'(-diff[i])
                                          : diff[i][COORD_WIDTH-1:0];
      end
   end

   // one multiplier per axis
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sq_in[i] = SqWidth'(mag_ff[i]) * SqWidth'(mag_ff[i]);
      end
   end

   // full width sum of the three squares
   always_comb begin
      sum_in = SumWidth'(sq_ff[0]) + SumWidth'(sq_ff[1]) + SumWidth'(sq_ff[2]);
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         mag_valid_ff <= mag_valid_in;
         sq_valid_ff  <= sq_valid_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (in_valid && mag_ready) begin
         mag_ff <= mag_in;
      end
      if (mag_valid_ff && sq_ready) begin
         sq_ff <= sq_in;
      end
      if (sq_valid_ff && sum_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_sum   = sum_ff;

endmodule : ed3d_front

`default_nettype wire

FILE: rtl/core/ed3d_root_cell.sv
// one square root cell: settles one root bit and hands the rest on
`default_nettype none

module ed3d_root_cell #(
   parameter int ROOT_WIDTH = ed3d_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [2*ROOT_WIDTH-1:0]   in_rad,
   input  logic [ROOT_WIDTH+1:0]     in_rem,
   input  logic [ROOT_WIDTH-1:0]     in_root,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [2*ROOT_WIDTH-1:0]   out_rad,
   output logic [ROOT_WIDTH+1:0]     out_rem,
   output logic [ROOT_WIDTH-1:0]     out_root
);

   localparam int RadWidth = 2 * ROOT_WIDTH;
   localparam int RemWidth = ROOT_WIDTH + 2;

   logic                  valid_ff, valid_in;
   logic [RadWidth-1:0]   rad_ff, rad_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0] root_ff, root_in;
   logic [RemWidth-1:0]   rem_shift;
   logic [RemWidth-1:0]   trial;
   logic                  take;

   // bring down the next two radicand bits and try the next root bit
   always_comb begin
      rem_shift = {in_rem[ROOT_WIDTH-1:0], in_rad[RadWidth-1 -: 2]};
      trial     = {in_root, 2'b01};
      take      = (rem_shift >= trial);
      rem_in    = take ? (rem_shift - trial) : rem_shift;
      root_in   = {in_root[ROOT_WIDTH-2:0], take};
      rad_in    = {in_rad[RadWidth-3:0], 2'b00};
   end

   // handshake toward the neighbors
   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule : ed3d_root_cell

`default_nettype wire

FILE: rtl/core/euclidean_distance_3d_top.sv
// top level of the 3d euclidean distance block
//
// Each request carries two points a and b with signed q8.8 coordinates of
// COORD_WIDTH bits. The response carries the truncated distance between
// them, floor(sqrt(dx^2 + dy^2 + dz^2)), as an unsigned 17-bit q9.8 value.
// Both channels use valid/stall: a transfer happens at a rising edge with
// valid high and stall low.
// Pipeline: three front stages for difference, square and sum, then one
// square root cell per root bit, COORD_WIDTH + 1 cells.
// Throughput: one request per cycle while rsp_stall is low; every stage
// and every cell holds its own request, so the pipeline carries up to
// COORD_WIDTH + 4 in flight.
// When rsp_stall is high, requests pile up behind the output; empty stages
// keep closing up, and req_stall rises only when every stage is occupied.
// Reset (synchronous, active high) empties the pipeline; the block has no
// other state and no configuration.
`default_nettype none

module euclidean_distance_3d_top #(
   parameter int COORD_WIDTH = ed3d_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_a_x,
   input  logic signed [COORD_WIDTH-1:0]     req_a_y,
   input  logic signed [COORD_WIDTH-1:0]     req_a_z,
   input  logic signed [COORD_WIDTH-1:0]     req_b_x,
   input  logic signed [COORD_WIDTH-1:0]     req_b_y,
   input  logic signed [COORD_WIDTH-1:0]     req_b_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic        [ed3d_pkg::DIST_WIDTH-1:0] rsp_distance
);

   import ed3d_pkg::*;

   localparam int RootWidth = COORD_WIDTH + 1;
   localparam int RadWidth  = 2 * RootWidth;
   localparam int RemWidth  = RootWidth + 2;

   logic signed [COORD_WIDTH-1:0] coord_a [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] coord_b [NUM_AXES];
   logic                          front_ready;
   logic                          chain_valid [RootWidth+1];
   logic                          chain_ready [RootWidth+1];
   logic [RadWidth-1:0]           chain_rad   [RootWidth+1];
   logic [RemWidth-1:0]           chain_rem   [RootWidth+1];
   logic [RootWidth-1:0]          chain_root  [RootWidth+1];

   // gather coordinates per axis
   always_comb begin
      coord_a[0] = req_a_x;
      coord_a[1] = req_a_y;
      coord_a[2] = req_a_z;
      coord_b[0] = req_b_x;
      coord_b[1] = req_b_y;
      coord_b[2] = req_b_z;
   end

   assign req_stall = !front_ready;

   // difference, square and sum stages
   ed3d_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_a      (coord_a),
      .in_b      (coord_b),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_sum   (chain_rad[0])
   );

   // square root starts from empty remainder and root
   assign chain_rem[0]  = '0;
   assign chain_root[0] = '0;

   // one cell per root bit, most significant first
   for (genvar k = 0; k < RootWidth; k++) begin : g_cell
      ed3d_root_cell #(
         .ROOT_WIDTH (RootWidth)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_rad    (chain_rad[k]),
         .in_rem    (chain_rem[k]),
         .in_root   (chain_root[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_rad   (chain_rad[k+1]),
         .out_rem   (chain_rem[k+1]),
         .out_root  (chain_root[k+1])
      );
   end

   // response side
   assign rsp_valid               = chain_valid[RootWidth];
   assign chain_ready[RootWidth]  = !rsp_stall;

   if (RootWidth >= DIST_WIDTH) begin : g_dist_trunc
      assign rsp_distance = chain_root[RootWidth][DIST_WIDTH-1:0];
   end else begin : g_dist_ext
      assign rsp_distance = DIST_WIDTH'(chain_root[RootWidth]);
   end

`ifndef SYNTH
   // the root is the floor: remainder never exceeds twice the root
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      chain_valid[RootWidth] |->
         (chain_rem[RootWidth] <= {1'b0, chain_root[RootWidth], 1'b0}))
      else $error("square root remainder too large");

   // input stalls only while a full pipeline waits on the receiver
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && chain_valid[0]))
      else $error("request stalled with room in the pipeline");

   // with the response side open every stage can move, so input never stalls
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      (!rsp_stall) |-> !req_stall)
      else $error("request stalled while response side is open");
`endif

endmodule : euclidean_distance_3d_top

`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for the 3d euclidean distance block: directed and random point pairs
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW             = ed3d_pkg::COORD_WIDTH_DEF;
   localparam int DW             = ed3d_pkg::DIST_WIDTH;
   localparam int LATENCY        = CW + 3;
   localparam int RANDOM_PAIRS   = 850;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   // request gap patterns
   localparam int GAP_NONE   = 0;
   localparam int GAP_RANDOM = 1;
   localparam int GAP_SPARSE = 2;

   typedef struct {
      logic signed [CW-1:0] a_x, a_y, a_z;
      logic signed [CW-1:0] b_x, b_y, b_z;
   } point_pair_type;

   // expected distances in request order, compared against each response
   class distance_scoreboard_type;
      logic [DW-1:0] pending_distances[$];
      int            errors;
      int            compared;

      // floor of the euclidean distance, all intermediates at full width
      function logic [DW-1:0] floor_distance(point_pair_type p);
         longint          dx, dy, dz;
         longint unsigned rem, root, probe;
         dx    = longint'(p.b_x) - longint'(p.a_x);
         dy    = longint'(p.b_y) - longint'(p.a_y);
         dz    = longint'(p.b_z) - longint'(p.a_z);
         rem   = longint'(dx * dx + dy * dy + dz * dz);
         root  = 0;
         probe = 64'h1 << 62;
         while (probe > rem)
            probe >>= 2;
         // digit-by-digit square root, truncated
         while (probe != 0) begin
            if (rem >= root + probe) begin
               rem  -= root + probe;
               root  = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root[DW-1:0];
      endfunction

      function void note_request(point_pair_type p);
         pending_distances.push_back(floor_distance(p));
      endfunction

      function void check_distance(logic [DW-1:0] got);
         logic [DW-1:0] want;
         compared++;
         if (pending_distances.size() == 0) begin
            $error("distance: expected none, actual %0d", got);
            errors++;
            return;
         end
         want = pending_distances.pop_front();
         if (got !== want) begin
            $error("distance: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction

      function int pending();
         return pending_distances.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [CW-1:0] req_a_x, req_a_y, req_a_z;
   logic signed [CW-1:0] req_b_x, req_b_y, req_b_z;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [DW-1:0]        rsp_distance;

   distance_scoreboard_type board = new;
   bit              hold_long;
   bit              out_busy_mode = 1'b1;
   int              long_holds;
   int              sent_pairs;
   int              directed_pairs;
   int              idle_cycles;

   euclidean_distance_3d_top #(.COORD_WIDTH(CW)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_a_x      (req_a_x),
      .req_a_y      (req_a_y),
      .req_a_z      (req_a_z),
      .req_b_x      (req_b_x),
      .req_b_y      (req_b_y),
      .req_b_z      (req_b_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_distance (rsp_distance)
   );

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic point_pair_type make_pair(int ax, int ay, int az,
                                                int bx, int by, int bz);
      point_pair_type p;
      p.a_x = CW'(ax);
      p.a_y = CW'(ay);
      p.a_z = CW'(az);
      p.b_x = CW'(bx);
      p.b_y = CW'(by);
      p.b_z = CW'(bz);
      return p;
   endfunction

   // coordinate drawn from the full range or from the corner values
   function automatic int pick_coord(bit corner);
      int corners[5] = '{-32768, -1, 0, 1, 32767};
      if (corner)
         return corners[$urandom_range(0, 4)];
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // offer one request after a gap, hold it until accepted
   task automatic send_pair(point_pair_type p, int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_a_x   <= p.a_x;
      req_a_y   <= p.a_y;
      req_a_z   <= p.a_z;
      req_b_x   <= p.b_x;
      req_b_y   <= p.b_y;
      req_b_z   <= p.b_z;
      do @(posedge clock); while (req_stall);
      board.note_request(p);
      sent_pairs++;
   endtask

   // output side pacing: random holds per response, plus one long hold
   initial begin : output_pacing
      int hold;
      int taken;
      taken     = 0;
      rsp_stall = 1'b0;
      forever begin
         if (hold_long && long_holds == 0) begin
            hold = LONG_HOLD;
            long_holds++;
         end else if (out_busy_mode) begin
            hold = $urandom_range(0, 10);
         end else begin
            hold = 0;
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (taken % 40 == 0)
            out_busy_mode = ($urandom_range(0, 2) != 0);
      end
   end

   // compare every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_distance(rsp_distance);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      point_pair_type directed[$];
      point_pair_type p;
      int          gap_mode;
      int          gap;
      int          kind;
      int          delta;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_a_x   = '0;
      req_a_y   = '0;
      req_a_z   = '0;
      req_b_x   = '0;
      req_b_y   = '0;
      req_b_z   = '0;
      gap_mode  = GAP_NONE;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, identical points, extremes per axis and overall
      directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(1234, -567, 32767, 1234, -567, 32767));
      directed.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767));
      directed.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768));
      directed.push_back(make_pair(-32768, 0, 0, 32767, 0, 0));
      directed.push_back(make_pair(0, 32767, 0, 0, -32768, 0));
      directed.push_back(make_pair(0, 0, -32768, 0, 0, 32767));
      directed.push_back(make_pair(0, 0, 0, 1, 0, 0));
      directed.push_back(make_pair(0, 0, 0, 768, 1024, 0));
      directed.push_back(make_pair(-1, -1, -1, 0, 0, 0));
      directed.push_back(make_pair(0, 0, 0, -32768, -32768, -32768));
      directed.push_back(make_pair(32767, 32767, 32767, 0, 0, 0));
      directed.push_back(make_pair('h5555, 'h5555, 'h5555, 'hAAAA, 'hAAAA, 'hAAAA));
      directed.push_back(make_pair('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
      directed.push_back(make_pair(-32768, 32767, 0, 32767, -32768, -32768));
      directed.push_back(make_pair(256, 256, 256, 512, 512, 512));
      foreach (directed[i])
         send_pair(directed[i], $urandom_range(0, 3));
      directed_pairs = directed.size();

      // random pairs; the first burst runs without gaps against a long output hold
      hold_long = 1'b1;
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i % 50 == 0)
            gap_mode = (i < 100) ? GAP_NONE : $urandom_range(GAP_NONE, GAP_SPARSE);
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            p = make_pair(pick_coord(0), pick_coord(0), pick_coord(0),
                          pick_coord(0), pick_coord(0), pick_coord(0));
         end else if (kind < 8) begin
            // nearby points give small distances
            p = make_pair(pick_coord(0), pick_coord(0), pick_coord(0), 0, 0, 0);
            delta = $urandom_range(0, 64);
            p.b_x = p.a_x + CW'(delta - 32);
            delta = $urandom_range(0, 64);
            p.b_y = p.a_y + CW'(delta - 32);
            delta = $urandom_range(0, 64);
            p.b_z = p.a_z + CW'(delta - 32);
         end else begin
            p = make_pair(pick_coord(1), pick_coord(1), pick_coord(1),
                          pick_coord(1), pick_coord(1), pick_coord(1));
         end
         case (gap_mode)
            GAP_NONE:   gap = 0;
            GAP_RANDOM: gap = $urandom_range(0, 10);
            default:    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
         endcase
         send_pair(p, gap);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then give stray responses a chance to show up
      while (board.pending() != 0)
         @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (board.pending() != 0) begin
         $error("distance: %0d expected responses never arrived", board.pending());
         board.errors++;
      end

      $display("covered %0d point pairs (%0d directed), %0d distances compared",
               sent_pairs, directed_pairs, board.compared);
      $display("output held off for %0d cycles %0d time(s) while requests kept coming",
               LONG_HOLD, long_holds);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
